// ===== sv/ipv4_route_and_arp_resolver_assert.svh =====
// Assertion macros used by the checker of the IPv4 route and ARP resolver.
`ifndef IPV4_ROUTE_AND_ARP_RESOLVER_ASSERT_SVH
`define IPV4_ROUTE_AND_ARP_RESOLVER_ASSERT_SVH

// The consequent must hold in the clock after the antecedent.
`define IPRAR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// The consequent must hold in the same clock as the antecedent.
`define IPRAR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/iprar_pkg.sv =====
// Types and constants of the IPv4 route and ARP resolver.
`default_nettype none

package iprar_pkg;

   localparam int IP_W          = 32;
   localparam int MAC_W         = 48;
   localparam int PORT_W        = 2;
   localparam int TTL_W         = 8;
   localparam int SLOT_W        = 7;
   localparam int MODE_W        = 2;
   localparam int VERDICT_W     = 3;
   localparam int ROUTE_COUNT_W = 8;
   localparam int ARP_COUNT_W   = 7;
   localparam int CSR_DATA_W    = 8;
   localparam int CSR_INDEX_W   = 1;

   localparam logic [MODE_W-1:0] MODE_LOOKUP      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ROUTE_WRITE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ARP_WRITE   = 2'd2;

   localparam logic [VERDICT_W-1:0] VERDICT_FORWARD       = 3'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_TIME_EXCEEDED = 3'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_UNREACHABLE   = 3'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_NO_ARP        = 3'd3;
   localparam logic [VERDICT_W-1:0] VERDICT_WRITE_DONE    = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROUTE_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ARP_COUNT   = 1'b1;

   localparam logic [TTL_W-1:0] TTL_EXPIRE_MAX = 8'd1;

   typedef struct packed {
      logic [IP_W-1:0]   prefix;
      logic [IP_W-1:0]   mask;
      logic [IP_W-1:0]   hop;
      logic [PORT_W-1:0] port;
   } route_entry_type;

   typedef struct packed {
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } arp_entry_type;

   typedef struct packed {
      logic              done;
      logic              found;
      logic [PORT_W-1:0] port;
      logic [IP_W-1:0]   hop;
   } route_result_type;

   typedef struct packed {
      logic             done;
      logic             found;
      logic [MAC_W-1:0] mac;
   } arp_result_type;

endpackage

`default_nettype wire

// ===== sv/iprar_route_scan.sv =====
// Route table memory with a sequential longest-prefix-match scan.
`default_nettype none

module iprar_route_scan #(
   parameter int ROUTE_ENTRIES = 128
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   wr_en,
   input  wire  [$clog2(ROUTE_ENTRIES)-1:0]      wr_addr,
   input  wire  iprar_pkg::route_entry_type      wr_entry,
   input  wire                                   go,
   input  wire  [iprar_pkg::IP_W-1:0]            go_dest,
   input  wire  [$clog2(ROUTE_ENTRIES+1)-1:0]    go_count,
   output iprar_pkg::route_result_type           result
);

   localparam int RA  = $clog2(ROUTE_ENTRIES);
   localparam int RCW = $clog2(ROUTE_ENTRIES + 1);

   iprar_pkg::route_entry_type route_mem [ROUTE_ENTRIES];
   iprar_pkg::route_entry_type rd_entry_ff;

   logic                          active_ff, active_in;
   logic                          pend_ff, pend_in;
   logic                          found_ff, found_in;
   logic [RCW-1:0]                idx_ff, idx_in;
   logic [RCW-1:0]                count_ff, count_in;
   logic [iprar_pkg::IP_W-1:0]    dest_ff, dest_in;
   logic [iprar_pkg::IP_W-1:0]    best_mask_ff, best_mask_in;
   logic [iprar_pkg::IP_W-1:0]    best_hop_ff, best_hop_in;
   logic [iprar_pkg::PORT_W-1:0]  best_port_ff, best_port_in;

   logic issue;
   logic match;
   logic take;
   logic finish;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         route_mem[wr_addr] <= wr_entry;
      end
      if (issue) begin
         rd_entry_ff <= route_mem[idx_ff[RA-1:0]];
      end
   end

   always_comb begin
      issue  = active_ff && (idx_ff < count_ff);
      match  = pend_ff && ((dest_ff & rd_entry_ff.mask) ==
                           (rd_entry_ff.prefix & rd_entry_ff.mask));
      take   = match && (!found_ff || (rd_entry_ff.mask > best_mask_ff));
      finish = active_ff && !pend_ff && !issue;

      active_in    = active_ff && !finish;
      pend_in      = issue;
      idx_in       = issue ? idx_ff + RCW'(1) : idx_ff;
      count_in     = count_ff;
      dest_in      = dest_ff;
      found_in     = found_ff || take;
      best_mask_in = take ? rd_entry_ff.mask : best_mask_ff;
      best_hop_in  = take ? rd_entry_ff.hop  : best_hop_ff;
      best_port_in = take ? rd_entry_ff.port : best_port_ff;

      if (go) begin
         active_in = 1'b1;
         pend_in   = 1'b0;
         idx_in    = '0;
         count_in  = go_count;
         dest_in   = go_dest;
         found_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         found_ff  <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
         found_ff  <= found_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff     <= count_in;
      dest_ff      <= dest_in;
      best_mask_ff <= best_mask_in;
      best_hop_ff  <= best_hop_in;
      best_port_ff <= best_port_in;
   end

   assign result.done  = finish;
   assign result.found = found_ff;
   assign result.port  = best_port_ff;
   assign result.hop   = best_hop_ff;

endmodule

`default_nettype wire

// ===== sv/iprar_arp_scan.sv =====
// ARP table memory with a sequential first-match search.
`default_nettype none

module iprar_arp_scan #(
   parameter int ARP_ENTRIES = 64
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 wr_en,
   input  wire  [$clog2(ARP_ENTRIES)-1:0]      wr_addr,
   input  wire  iprar_pkg::arp_entry_type      wr_entry,
   input  wire                                 go,
   input  wire  [iprar_pkg::IP_W-1:0]          go_key,
   input  wire  [$clog2(ARP_ENTRIES+1)-1:0]    go_count,
   output iprar_pkg::arp_result_type           result
);

   localparam int AA  = $clog2(ARP_ENTRIES);
   localparam int ACW = $clog2(ARP_ENTRIES + 1);

   iprar_pkg::arp_entry_type arp_mem [ARP_ENTRIES];
   iprar_pkg::arp_entry_type rd_entry_ff;

   logic                        active_ff, active_in;
   logic                        pend_ff, pend_in;
   logic [ACW-1:0]              idx_ff, idx_in;
   logic [ACW-1:0]              count_ff, count_in;
   logic [iprar_pkg::IP_W-1:0]  key_ff, key_in;

   logic hit;
   logic issue;
   logic finish;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         arp_mem[wr_addr] <= wr_entry;
      end
      if (issue) begin
         rd_entry_ff <= arp_mem[idx_ff[AA-1:0]];
      end
   end

   always_comb begin
      hit    = pend_ff && (rd_entry_ff.ip == key_ff);
      issue  = active_ff && !hit && (idx_ff < count_ff);
      finish = active_ff && (hit || (!pend_ff && !issue));

      active_in = active_ff && !finish;
      pend_in   = issue;
      idx_in    = issue ? idx_ff + ACW'(1) : idx_ff;
      count_in  = count_ff;
      key_in    = key_ff;

      if (go) begin
         active_in = 1'b1;
         pend_in   = 1'b0;
         idx_in    = '0;
         count_in  = go_count;
         key_in    = go_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      key_ff   <= key_in;
   end

   assign result.done  = finish;
   assign result.found = hit;
   assign result.mac   = rd_entry_ff.mac;

endmodule

`default_nettype wire

// ===== sv/ipv4_route_and_arp_resolver.sv =====
// Top level of the IPv4 route and ARP resolver: sequencer, registers and result stage.
`default_nettype none

// One item is taken at a time: busy stays high from the transfer of a lookup until its
// verdict is known, and each verdict appears on the rsp_ ports for one cycle, the cycle
// that follows the edge at which it is decided, with no way for the receiver to hold it
// off. Route writes, ARP writes, unused modes and lookups with an expired TTL finish at
// the edge of their transfer and leave busy low. Any other lookup reads the route memory
// one entry per cycle, then the ARP memory one entry per cycle until the first hit, with
// both route_count and arp_count limited to the table depths. Writes to slots within the
// table depth take effect at the edge of their transfer.
module ipv4_route_and_arp_resolver #(
   parameter int ROUTE_ENTRIES = 128,
   parameter int ARP_ENTRIES   = 64,
   parameter int PORT_COUNT    = 4
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  wire  [iprar_pkg::MODE_W-1:0]          req_mode,
   input  wire  [iprar_pkg::SLOT_W-1:0]          req_slot,
   input  wire  [iprar_pkg::IP_W-1:0]            req_ip_address,
   input  wire  [iprar_pkg::IP_W-1:0]            req_prefix_mask,
   input  wire  [iprar_pkg::IP_W-1:0]            req_next_hop_address,
   input  wire  [iprar_pkg::PORT_W-1:0]          req_egress_port,
   input  wire  [iprar_pkg::MAC_W-1:0]           req_hardware_address,
   input  wire  [iprar_pkg::TTL_W-1:0]           req_packet_ttl,
   output logic                                  rsp_valid,
   output logic [iprar_pkg::VERDICT_W-1:0]       rsp_verdict,
   output logic [iprar_pkg::PORT_W-1:0]          rsp_out_port,
   output logic [iprar_pkg::MAC_W-1:0]           rsp_next_hop_mac,
   output logic [iprar_pkg::TTL_W-1:0]           rsp_new_ttl,
   input  wire                                   csr_write_enable,
   input  wire  [iprar_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [iprar_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int RA  = $clog2(ROUTE_ENTRIES);
   localparam int RCW = $clog2(ROUTE_ENTRIES + 1);
   localparam int AA  = $clog2(ARP_ENTRIES);
   localparam int ACW = $clog2(ARP_ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ROUTE = 3'b010,
      ST_ARP   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [iprar_pkg::ROUTE_COUNT_W-1:0] route_count_ff, route_count_in;
   logic [iprar_pkg::ARP_COUNT_W-1:0]   arp_count_ff, arp_count_in;

   logic [iprar_pkg::TTL_W-1:0]         ttl_ff, ttl_in;
   logic [iprar_pkg::PORT_W-1:0]        port_ff, port_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [iprar_pkg::VERDICT_W-1:0]     rsp_verdict_ff, rsp_verdict_in;
   logic [iprar_pkg::PORT_W-1:0]        rsp_port_ff, rsp_port_in;
   logic [iprar_pkg::MAC_W-1:0]         rsp_mac_ff, rsp_mac_in;
   logic [iprar_pkg::TTL_W-1:0]         rsp_ttl_ff, rsp_ttl_in;

   logic                                accept;
   logic                                route_wr_en;
   logic                                arp_wr_en;
   logic                                route_go;
   logic                                arp_go;
   logic [RCW-1:0]                      route_n;
   logic [ACW-1:0]                      arp_n;
   iprar_pkg::route_entry_type          route_wr_entry;
   iprar_pkg::arp_entry_type            arp_wr_entry;
   iprar_pkg::route_result_type         route_res;
   iprar_pkg::arp_result_type           arp_res;

   assign busy   = reset || (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign route_n = (32'(route_count_ff) > ROUTE_ENTRIES) ? RCW'(ROUTE_ENTRIES)
                                                          : RCW'(route_count_ff);
   assign arp_n   = (32'(arp_count_ff) > ARP_ENTRIES) ? ACW'(ARP_ENTRIES)
                                                      : ACW'(arp_count_ff);

   assign route_wr_en = accept && (req_mode == iprar_pkg::MODE_ROUTE_WRITE) &&
                        (32'(req_slot) < ROUTE_ENTRIES);
   assign arp_wr_en   = accept && (req_mode == iprar_pkg::MODE_ARP_WRITE) &&
                        (32'(req_slot) < ARP_ENTRIES);

   // Ports at or above the interface count are stored as the highest interface.
   assign route_wr_entry.prefix = req_ip_address;
   assign route_wr_entry.mask   = req_prefix_mask;
   assign route_wr_entry.hop    = req_next_hop_address;
   assign route_wr_entry.port   = (32'(req_egress_port) >= PORT_COUNT)
                                  ? iprar_pkg::PORT_W'(PORT_COUNT - 1) : req_egress_port;

   assign arp_wr_entry.ip  = req_ip_address;
   assign arp_wr_entry.mac = req_hardware_address;

   iprar_route_scan #(
      .ROUTE_ENTRIES(ROUTE_ENTRIES)
   ) u_route_scan (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (route_wr_en),
      .wr_addr  (RA'(req_slot)),
      .wr_entry (route_wr_entry),
      .go       (route_go),
      .go_dest  (req_ip_address),
      .go_count (route_n),
      .result   (route_res)
   );

   iprar_arp_scan #(
      .ARP_ENTRIES(ARP_ENTRIES)
   ) u_arp_scan (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (arp_wr_en),
      .wr_addr  (AA'(req_slot)),
      .wr_entry (arp_wr_entry),
      .go       (arp_go),
      .go_key   (route_res.hop),
      .go_count (arp_n),
      .result   (arp_res)
   );

   always_comb begin
      route_count_in = route_count_ff;
      arp_count_in   = arp_count_ff;
      if (csr_write_enable) begin
         case (csr_index)
            iprar_pkg::CSR_ROUTE_COUNT: begin
               route_count_in = csr_write_data;
            end
            iprar_pkg::CSR_ARP_COUNT: begin
               arp_count_in = csr_write_data[iprar_pkg::ARP_COUNT_W-1:0];
            end
            default: begin
               route_count_in = route_count_ff;
            end
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      ttl_in         = ttl_ff;
      port_in        = port_ff;
      route_go       = 1'b0;
      arp_go         = 1'b0;
      rsp_valid_in   = 1'b0;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_port_in    = rsp_port_ff;
      rsp_mac_in     = rsp_mac_ff;
      rsp_ttl_in     = rsp_ttl_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_port_in = '0;
               rsp_mac_in  = '0;
               rsp_ttl_in  = req_packet_ttl;
               if (req_mode != iprar_pkg::MODE_LOOKUP) begin
                  rsp_valid_in   = 1'b1;
                  rsp_verdict_in = iprar_pkg::VERDICT_WRITE_DONE;
               end else if (req_packet_ttl <= iprar_pkg::TTL_EXPIRE_MAX) begin
                  rsp_valid_in   = 1'b1;
                  rsp_verdict_in = iprar_pkg::VERDICT_TIME_EXCEEDED;
               end else begin
                  route_go = 1'b1;
                  ttl_in   = req_packet_ttl;
                  state_in = ST_ROUTE;
               end
            end
         end
         ST_ROUTE: begin
            if (route_res.done) begin
               if (route_res.found) begin
                  arp_go   = 1'b1;
                  port_in  = route_res.port;
                  state_in = ST_ARP;
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_verdict_in = iprar_pkg::VERDICT_UNREACHABLE;
                  rsp_port_in    = '0;
                  rsp_mac_in     = '0;
                  rsp_ttl_in     = ttl_ff;
                  state_in       = ST_IDLE;
               end
            end
         end
         ST_ARP: begin
            if (arp_res.done) begin
               rsp_valid_in = 1'b1;
               rsp_port_in  = port_ff;
               state_in     = ST_IDLE;
               if (arp_res.found) begin
                  rsp_verdict_in = iprar_pkg::VERDICT_FORWARD;
                  rsp_mac_in     = arp_res.mac;
                  rsp_ttl_in     = ttl_ff - iprar_pkg::TTL_W'(1);
               end else begin
                  rsp_verdict_in = iprar_pkg::VERDICT_NO_ARP;
                  rsp_mac_in     = '0;
                  rsp_ttl_in     = ttl_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         route_count_ff <= '0;
         arp_count_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         route_count_ff <= route_count_in;
         arp_count_ff   <= arp_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ttl_ff         <= ttl_in;
      port_ff        <= port_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_port_ff    <= rsp_port_in;
      rsp_mac_ff     <= rsp_mac_in;
      rsp_ttl_ff     <= rsp_ttl_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_verdict      = rsp_verdict_ff;
   assign rsp_out_port     = rsp_port_ff;
   assign rsp_next_hop_mac = rsp_mac_ff;
   assign rsp_new_ttl      = rsp_ttl_ff;

endmodule

`default_nettype wire

// ===== sv/iprar_checker.sv =====
// Port-level checker of the IPv4 route and ARP resolver and its bind statement.
`default_nettype none

`include "ipv4_route_and_arp_resolver_assert.svh"

module iprar_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                start,
   input wire                                busy,
   input wire [iprar_pkg::MODE_W-1:0]        req_mode,
   input wire [iprar_pkg::TTL_W-1:0]         req_packet_ttl,
   input wire                                rsp_valid,
   input wire [iprar_pkg::VERDICT_W-1:0]     rsp_verdict,
   input wire [iprar_pkg::PORT_W-1:0]        rsp_out_port,
   input wire [iprar_pkg::MAC_W-1:0]         rsp_next_hop_mac,
   input wire [iprar_pkg::TTL_W-1:0]         rsp_new_ttl
);

   logic take_write;
   logic take_expired;
   logic take_lookup;

   assign take_write   = !reset && start && !busy && (req_mode != iprar_pkg::MODE_LOOKUP);
   assign take_expired = !reset && start && !busy && (req_mode == iprar_pkg::MODE_LOOKUP) &&
                         (req_packet_ttl <= iprar_pkg::TTL_EXPIRE_MAX);
   assign take_lookup  = !reset && start && !busy && (req_mode == iprar_pkg::MODE_LOOKUP) &&
                         (req_packet_ttl > iprar_pkg::TTL_EXPIRE_MAX);

   `IPRAR_ASSERT_NEXT(a_write_done, clock, reset, take_write, rsp_valid && rsp_verdict == iprar_pkg::VERDICT_WRITE_DONE && rsp_new_ttl == $past(req_packet_ttl), "Write transfer did not answer write done in the next cycle.")
   `IPRAR_ASSERT_NEXT(a_ttl_expired, clock, reset, take_expired, rsp_valid && rsp_verdict == iprar_pkg::VERDICT_TIME_EXCEEDED && rsp_new_ttl == $past(req_packet_ttl), "Expired lookup did not answer time exceeded in the next cycle.")
   `IPRAR_ASSERT_NEXT(a_lookup_busy, clock, reset, take_lookup, busy && !rsp_valid, "Live lookup did not hold busy while the tables are scanned.")
   `IPRAR_ASSERT_NOW(a_zero_fields, clock, reset, rsp_valid && (rsp_verdict == iprar_pkg::VERDICT_WRITE_DONE || rsp_verdict == iprar_pkg::VERDICT_TIME_EXCEEDED || rsp_verdict == iprar_pkg::VERDICT_UNREACHABLE), rsp_out_port == '0 && rsp_next_hop_mac == '0, "Verdict without a route carried a port or MAC.")

endmodule

bind ipv4_route_and_arp_resolver iprar_checker u_iprar_checker (.*);

`default_nettype wire

// ===== tb/ipv4_route_and_arp_resolver_test.sv =====
// Self-checking testbench for the IPv4 route and ARP resolver with its own forwarding predictor.
module ipv4_route_and_arp_resolver_test;

   localparam int ROUTE_DEPTH = 128;
   localparam int ARP_DEPTH = 64;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int RANDOM_PHASES = 12;
   localparam int ITEMS_PER_PHASE = 85;
   localparam logic [iprar_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [iprar_pkg::IP_W-1:0] HOP_A = 32'hC0A8_0001;
   localparam logic [iprar_pkg::IP_W-1:0] HOP_B = 32'hC0A8_0002;
   localparam logic [iprar_pkg::IP_W-1:0] HOP_C = 32'hC0A8_0003;
   localparam logic [iprar_pkg::IP_W-1:0] HOP_D = 32'hFFFF_FFFE;

   typedef struct packed {
      logic [iprar_pkg::MODE_W-1:0] mode;
      logic [iprar_pkg::SLOT_W-1:0] slot;
      logic [iprar_pkg::IP_W-1:0]   ip;
      logic [iprar_pkg::IP_W-1:0]   mask;
      logic [iprar_pkg::IP_W-1:0]   hop;
      logic [iprar_pkg::PORT_W-1:0] port;
      logic [iprar_pkg::MAC_W-1:0]  mac;
      logic [iprar_pkg::TTL_W-1:0]  ttl;
   } packet_item_type;

   typedef struct packed {
      logic [iprar_pkg::VERDICT_W-1:0] verdict;
      logic [iprar_pkg::PORT_W-1:0]    port;
      logic [iprar_pkg::MAC_W-1:0]     mac;
      logic [iprar_pkg::TTL_W-1:0]     ttl;
   } forward_decision_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [iprar_pkg::MODE_W-1:0]        req_mode = '0;
   logic [iprar_pkg::SLOT_W-1:0]        req_slot = '0;
   logic [iprar_pkg::IP_W-1:0]          req_ip_address = '0;
   logic [iprar_pkg::IP_W-1:0]          req_prefix_mask = '0;
   logic [iprar_pkg::IP_W-1:0]          req_next_hop_address = '0;
   logic [iprar_pkg::PORT_W-1:0]        req_egress_port = '0;
   logic [iprar_pkg::MAC_W-1:0]         req_hardware_address = '0;
   logic [iprar_pkg::TTL_W-1:0]         req_packet_ttl = '0;
   logic                                rsp_valid;
   logic [iprar_pkg::VERDICT_W-1:0]     rsp_verdict;
   logic [iprar_pkg::PORT_W-1:0]        rsp_out_port;
   logic [iprar_pkg::MAC_W-1:0]         rsp_next_hop_mac;
   logic [iprar_pkg::TTL_W-1:0]         rsp_new_ttl;
   logic                                csr_write_enable = 1'b0;
   logic [iprar_pkg::CSR_INDEX_W-1:0]   csr_index = '0;
   logic [iprar_pkg::CSR_DATA_W-1:0]    csr_write_data = '0;

   iprar_pkg::route_entry_type          route_table [ROUTE_DEPTH];
   iprar_pkg::arp_entry_type            arp_shadow [ARP_DEPTH];
   logic [iprar_pkg::ROUTE_COUNT_W-1:0] routes_in_use = '0;
   logic [iprar_pkg::ARP_COUNT_W-1:0]   arps_in_use = '0;

   packet_item_type          pending_items [$];
   packet_item_type          current_item;
   forward_decision_type     expected_decisions [$];
   forward_decision_type     oldest_decision;
   logic [iprar_pkg::IP_W-1:0] net_pool [8];
   logic [iprar_pkg::IP_W-1:0] hop_pool [12];
   int                       accepted_count = 0;
   int                       result_count = 0;
   int                       mismatch_count = 0;
   int                       cycle_count = 0;

   ipv4_route_and_arp_resolver u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_slot(req_slot),
      .req_ip_address(req_ip_address),
      .req_prefix_mask(req_prefix_mask),
      .req_next_hop_address(req_next_hop_address),
      .req_egress_port(req_egress_port),
      .req_hardware_address(req_hardware_address),
      .req_packet_ttl(req_packet_ttl),
      .rsp_valid(rsp_valid),
      .rsp_verdict(rsp_verdict),
      .rsp_out_port(rsp_out_port),
      .rsp_next_hop_mac(rsp_next_hop_mac),
      .rsp_new_ttl(rsp_new_ttl),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   function automatic forward_decision_type resolve_packet(input packet_item_type it);
      forward_decision_type d;
      int route_limit;
      int arp_limit;
      int best;
      d.verdict = iprar_pkg::VERDICT_WRITE_DONE;
      d.port = '0;
      d.mac = '0;
      d.ttl = it.ttl;
      best = -1;
      route_limit = (routes_in_use > ROUTE_DEPTH) ? ROUTE_DEPTH : routes_in_use;
      arp_limit = (arps_in_use > ARP_DEPTH) ? ARP_DEPTH : arps_in_use;
      case (it.mode)
         iprar_pkg::MODE_ROUTE_WRITE: begin
            route_table[it.slot].prefix = it.ip;
            route_table[it.slot].mask = it.mask;
            route_table[it.slot].hop = it.hop;
            route_table[it.slot].port = it.port;
         end
         iprar_pkg::MODE_ARP_WRITE: begin
            if (it.slot < ARP_DEPTH) begin
               arp_shadow[it.slot].ip = it.ip;
               arp_shadow[it.slot].mac = it.mac;
            end
         end
         iprar_pkg::MODE_LOOKUP: begin
            if (it.ttl <= iprar_pkg::TTL_EXPIRE_MAX) begin
               d.verdict = iprar_pkg::VERDICT_TIME_EXCEEDED;
            end else begin
               for (int i = 0; i < route_limit; i++) begin
                  if ((it.ip & route_table[i].mask) ==
                      (route_table[i].prefix & route_table[i].mask) &&
                      (best < 0 || route_table[i].mask > route_table[best].mask)) begin
                     best = i;
                  end
               end
               if (best < 0) begin
                  d.verdict = iprar_pkg::VERDICT_UNREACHABLE;
               end else begin
                  d.verdict = iprar_pkg::VERDICT_NO_ARP;
                  d.port = route_table[best].port;
                  for (int i = 0; i < arp_limit; i++) begin
                     if (d.verdict == iprar_pkg::VERDICT_NO_ARP &&
                         arp_shadow[i].ip == route_table[best].hop) begin
                        d.verdict = iprar_pkg::VERDICT_FORWARD;
                        d.mac = arp_shadow[i].mac;
                        d.ttl = it.ttl - iprar_pkg::TTL_W'(1);
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      return d;
   endfunction

   function automatic packet_item_type noise_item();
      packet_item_type it;
      it.mode = iprar_pkg::MODE_W'($urandom);
      it.slot = iprar_pkg::SLOT_W'($urandom);
      it.ip = $urandom;
      it.mask = $urandom;
      it.hop = $urandom;
      it.port = iprar_pkg::PORT_W'($urandom);
      it.mac = iprar_pkg::MAC_W'({$urandom, $urandom});
      it.ttl = iprar_pkg::TTL_W'($urandom);
      return it;
   endfunction

   function automatic packet_item_type lookup(input logic [iprar_pkg::IP_W-1:0] ip,
                                              input logic [iprar_pkg::TTL_W-1:0] ttl);
      packet_item_type it;
      it = noise_item();
      it.mode = iprar_pkg::MODE_LOOKUP;
      it.ip = ip;
      it.ttl = ttl;
      return it;
   endfunction

   function automatic packet_item_type route_write(input logic [iprar_pkg::SLOT_W-1:0] slot,
                                                   input logic [iprar_pkg::IP_W-1:0] prefix,
                                                   input logic [iprar_pkg::IP_W-1:0] mask,
                                                   input logic [iprar_pkg::IP_W-1:0] hop,
                                                   input logic [iprar_pkg::PORT_W-1:0] port);
      packet_item_type it;
      it = noise_item();
      it.mode = iprar_pkg::MODE_ROUTE_WRITE;
      it.slot = slot;
      it.ip = prefix;
      it.mask = mask;
      it.hop = hop;
      it.port = port;
      return it;
   endfunction

   function automatic packet_item_type arp_write(input logic [iprar_pkg::SLOT_W-1:0] slot,
                                                 input logic [iprar_pkg::IP_W-1:0] ip,
                                                 input logic [iprar_pkg::MAC_W-1:0] mac);
      packet_item_type it;
      it = noise_item();
      it.mode = iprar_pkg::MODE_ARP_WRITE;
      it.slot = slot;
      it.ip = ip;
      it.mac = mac;
      return it;
   endfunction

   function automatic logic [iprar_pkg::IP_W-1:0] random_mask();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return $urandom;
      if (pick < 15) return '0;
      if (pick < 25) return '1;
      return ~32'h0 << (32 - $urandom_range(1, 31));
   endfunction

   function automatic packet_item_type random_route(input logic [iprar_pkg::SLOT_W-1:0] slot);
      packet_item_type it;
      it = noise_item();
      it.mode = iprar_pkg::MODE_ROUTE_WRITE;
      it.slot = slot;
      it.mask = random_mask();
      it.ip = net_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 1) != 0) it.ip = it.ip ^ ($urandom & ~it.mask);
      if ($urandom_range(0, 6) != 0) it.hop = hop_pool[$urandom_range(0, 11)];
      return it;
   endfunction

   function automatic packet_item_type random_arp(input logic [iprar_pkg::SLOT_W-1:0] slot);
      packet_item_type it;
      it = noise_item();
      it.mode = iprar_pkg::MODE_ARP_WRITE;
      it.slot = slot;
      if ($urandom_range(0, 6) != 0) it.ip = hop_pool[$urandom_range(0, 11)];
      return it;
   endfunction

   task automatic queue_random_item();
      packet_item_type it;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         it = lookup($urandom, iprar_pkg::TTL_W'($urandom_range(2, 255)));
         if ($urandom_range(0, 9) == 0) it.ttl = iprar_pkg::TTL_W'($urandom_range(0, 1));
         if ($urandom_range(0, 3) != 0) begin
            it.ip = net_pool[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(0, 32));
         end
      end else if (pick < 77) begin
         it = random_route(iprar_pkg::SLOT_W'($urandom));
      end else if (pick < 94) begin
         it = random_arp(iprar_pkg::SLOT_W'($urandom_range(0, (pick < 80) ? 127 : 63)));
      end else begin
         it = noise_item();
         it.mode = MODE_UNUSED;
      end
      pending_items.push_back(it);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] seen,
                                  input logic [63:0] wanted);
      mismatch_count++;
      $display("mismatch at result %0d: %s got %h expected %h",
               result_count, what, seen, wanted);
   endtask

   task automatic wait_idle();
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < 4) begin
         @(posedge clock);
         if (pending_items.size() == 0 && !start && !busy &&
             expected_decisions.size() == 0) begin
            quiet_cycles++;
         end else begin
            quiet_cycles = 0;
         end
      end
   endtask

   task automatic write_register(input logic [iprar_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [iprar_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == iprar_pkg::CSR_ROUTE_COUNT) begin
         routes_in_use = data;
      end else begin
         arps_in_use = data[iprar_pkg::ARP_COUNT_W-1:0];
      end
   endtask

   task automatic set_counts(input logic [iprar_pkg::CSR_DATA_W-1:0] routes,
                             input logic [iprar_pkg::CSR_DATA_W-1:0] arps);
      wait_idle();
      write_register(iprar_pkg::CSR_ROUTE_COUNT, routes);
      write_register(iprar_pkg::CSR_ARP_COUNT, arps);
   endtask

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            expected_decisions.push_back(resolve_packet(current_item));
            accepted_count++;
         end
         if (pending_items.size() != 0 &&
             ((accepted_count >= 500 && accepted_count < 800) ||
              $urandom_range(0, 99) >= 13)) begin
            current_item = pending_items.pop_front();
            start <= 1'b1;
         end else begin
            current_item = noise_item();
            start <= 1'b0;
         end
         req_mode <= current_item.mode;
         req_slot <= current_item.slot;
         req_ip_address <= current_item.ip;
         req_prefix_mask <= current_item.mask;
         req_next_hop_address <= current_item.hop;
         req_egress_port <= current_item.port;
         req_hardware_address <= current_item.mac;
         req_packet_ttl <= current_item.ttl;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         result_count++;
         if (expected_decisions.size() == 0) begin
            report_mismatch("unexpected transfer, verdict", 64'(rsp_verdict), 64'(0));
         end else begin
            oldest_decision = expected_decisions.pop_front();
            if (rsp_verdict !== oldest_decision.verdict) begin
               report_mismatch("verdict", 64'(rsp_verdict), 64'(oldest_decision.verdict));
            end
            if (rsp_out_port !== oldest_decision.port) begin
               report_mismatch("out_port", 64'(rsp_out_port), 64'(oldest_decision.port));
            end
            if (rsp_next_hop_mac !== oldest_decision.mac) begin
               report_mismatch("next_hop_mac", 64'(rsp_next_hop_mac),
                               64'(oldest_decision.mac));
            end
            if (rsp_new_ttl !== oldest_decision.ttl) begin
               report_mismatch("new_ttl", 64'(rsp_new_ttl), 64'(oldest_decision.ttl));
            end
         end
      end
   end

   initial begin
      packet_item_type unused_item;
      logic [iprar_pkg::CSR_DATA_W-1:0] routes;
      logic [iprar_pkg::CSR_DATA_W-1:0] arps;
      foreach (route_table[i]) route_table[i] = '0;
      foreach (arp_shadow[i]) arp_shadow[i] = '0;
      foreach (net_pool[i]) net_pool[i] = $urandom;
      foreach (hop_pool[i]) hop_pool[i] = $urandom;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      pending_items.push_back(lookup(32'h0A01_0207, 8'd0));
      pending_items.push_back(lookup(32'hFFFF_FFFF, 8'd1));
      pending_items.push_back(lookup(32'h0000_0000, 8'd2));
      unused_item = noise_item();
      unused_item.mode = MODE_UNUSED;
      unused_item.ttl = 8'd255;
      pending_items.push_back(unused_item);
      pending_items.push_back(arp_write(7'd127, HOP_A, 48'h0));
      pending_items.push_back(route_write(7'd0, 32'h0A00_0000, 32'hFF00_0000, HOP_A, 2'd1));
      pending_items.push_back(route_write(7'd1, 32'h0A01_0000, 32'hFFFF_0000, HOP_B, 2'd2));
      pending_items.push_back(route_write(7'd2, 32'h0A01_0200, 32'hFFFF_FF00, HOP_C, 2'd3));
      pending_items.push_back(route_write(7'd3, 32'h0000_0000, 32'h0000_0000, HOP_A, 2'd0));
      pending_items.push_back(route_write(7'd4, 32'h0A01_FFFF, 32'hFFFF_0000, HOP_D, 2'd3));
      pending_items.push_back(route_write(7'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, HOP_D, 2'd2));
      pending_items.push_back(arp_write(7'd0, HOP_A, 48'hFFFF_FFFF_FFFF));
      pending_items.push_back(arp_write(7'd1, HOP_B, 48'h0));
      pending_items.push_back(arp_write(7'd2, HOP_B, 48'h1234_5678_9ABC));
      pending_items.push_back(arp_write(7'd3, HOP_D, 48'hA5A5_A5A5_A5A5));
      pending_items.push_back(arp_write(7'd4, 32'h0, 48'h5A5A_5A5A_5A5A));

      set_counts(8'd6, 8'd5);
      pending_items.push_back(lookup(32'h0A01_0207, 8'd64));
      pending_items.push_back(lookup(32'h0A01_0909, 8'd2));
      pending_items.push_back(lookup(32'h0AC8_0001, 8'd255));
      pending_items.push_back(lookup(32'hC0A8_0101, 8'd100));
      pending_items.push_back(lookup(32'hFFFF_FFFF, 8'd128));
      pending_items.push_back(lookup(32'h0A01_0207, 8'd1));

      set_counts(8'd2, 8'd0);
      pending_items.push_back(lookup(32'h0A01_0207, 8'd9));
      pending_items.push_back(lookup(32'hC0A8_0101, 8'd9));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               routes = 8'd128;
               arps = 8'd64;
            end
            1: begin
               routes = 8'd255;
               arps = 8'hFF;
            end
            2: begin
               routes = 8'd0;
               arps = 8'd64;
            end
            3: begin
               routes = 8'd128;
               arps = 8'd0;
            end
            4: begin
               routes = 8'd1;
               arps = 8'd1;
            end
            5: begin
               routes = 8'd129;
               arps = 8'd65;
            end
            default: begin
               routes = iprar_pkg::CSR_DATA_W'($urandom_range(0, 128));
               arps = iprar_pkg::CSR_DATA_W'($urandom_range(0, 64));
            end
         endcase
         set_counts(routes, arps);
         if (phase == 0) begin
            for (int s = 0; s < ROUTE_DEPTH; s++) begin
               pending_items.push_back(random_route(iprar_pkg::SLOT_W'(s)));
            end
            for (int s = 0; s < ARP_DEPTH; s++) begin
               pending_items.push_back(random_arp(iprar_pkg::SLOT_W'(s)));
            end
         end
         repeat (ITEMS_PER_PHASE) queue_random_item();
      end

      wait_idle();
      repeat (ROUTE_DEPTH + ARP_DEPTH + 8) @(posedge clock);
      if (expected_decisions.size() != 0) begin
         report_mismatch("results still outstanding", 64'(expected_decisions.size()), 64'(0));
      end
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== ipv4_route_and_arp_resolver.f =====
+incdir+sv
sv/iprar_pkg.sv
sv/iprar_route_scan.sv
sv/iprar_arp_scan.sv
sv/ipv4_route_and_arp_resolver.sv
sv/iprar_checker.sv
tb/ipv4_route_and_arp_resolver_test.sv
